FILE: design/bd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_pkg: shared types and constants of the bus decoder
// opcodes, region targets, the front-to-back command and the map constants
// ----------------------------------------------------------------------------
package bd_pkg;

	// offset width that covers regions of up to 2^27 bytes
	localparam int unsigned OFS_W = 27;
	localparam int unsigned SZ_W = OFS_W + 1;

	localparam int unsigned Q_DEPTH = 2;

	localparam int unsigned DEF_ROM_BYTES = 8388608;
	localparam int unsigned DEF_RAM_BYTES = 8388608;
	localparam int unsigned DEF_IO_BYTES = 131072;
	localparam logic [31:0] DEF_ROM_BASE_ADDR = 32'hAFC0_0000;
	localparam logic [31:0] DEF_ROM_ALIAS_ADDR = 32'h0FC0_0000;

	localparam logic [31:0] RAM_BASE0 = 32'h8000_0000;
	localparam logic [31:0] RAM_BASE1 = 32'hA000_0000;
	localparam logic [31:0] RAM_BASE2 = 32'h0000_0000;
	localparam logic [31:0] IO_BASE0 = 32'hB800_0000;
	localparam logic [31:0] IO_BASE1 = 32'h9800_0000;
	localparam logic [31:0] IO_BASE2 = 32'h1800_0000;

	localparam int unsigned UART_TX_OFS = 32'h18300;
	localparam int unsigned UART_LSR_OFS = 32'h18305;
	localparam logic [7:0] UART_LSR_READY = 8'h20;

	typedef enum logic [2:0] {
		OP_RD8  = 3'd0,
		OP_RD16 = 3'd1,
		OP_RD32 = 3'd2,
		OP_WR8  = 3'd3,
		OP_WR16 = 3'd4,
		OP_WR32 = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_ROM,
		TGT_RAM,
		TGT_IO
	} tgt_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_DATA,
		BK_STATUS
	} bk_state_t;

	typedef struct packed {
		tgt_t             tgt;
		logic             wr;
		logic [1:0]       sz;
		logic [OFS_W-1:0] ofs;
		logic [31:0]      wdata;
		logic             unm;
		logic             tx;
		logic [7:0]       txb;
		logic             lsr_rd;
	} bd_cmd_t;

endpackage
`default_nettype wire

FILE: design/bd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_req_if: bus access request channel
// valid/ready handshake carrying opcode, address and write data
// ----------------------------------------------------------------------------
interface bd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] address;
	logic [31:0] write_data;

	modport source (output valid, output opcode, output address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		output ready);
endinterface
`default_nettype wire

FILE: design/bd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_rsp_if: bus access response channel
// valid/ready handshake carrying read data, unmapped flag and uart byte
// ----------------------------------------------------------------------------
interface bd_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        unmapped;
	logic        tx_valid;
	logic [7:0]  tx_byte;

	modport source (output valid, output read_data, output unmapped, output tx_valid,
		output tx_byte, input ready);
	modport sink (input valid, input read_data, input unmapped, input tx_valid,
		input tx_byte, output ready);
endinterface
`default_nettype wire

FILE: design/bd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_ram: generic single-port ram
// one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module bd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/bd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_front: request intake and address decode
// registers the request with per-region range hits, then picks the region by
// priority, checks the access tail and flags uart transmit and status hits
// ----------------------------------------------------------------------------
module bd_front #(
	parameter int unsigned ROM_BYTES = bd_pkg::DEF_ROM_BYTES,
	parameter int unsigned RAM_BYTES = bd_pkg::DEF_RAM_BYTES,
	parameter int unsigned IO_BYTES = bd_pkg::DEF_IO_BYTES,
	parameter logic [31:0] ROM_BASE_ADDR = bd_pkg::DEF_ROM_BASE_ADDR,
	parameter logic [31:0] ROM_ALIAS_ADDR = bd_pkg::DEF_ROM_ALIAS_ADDR
) (
	input  logic            clk,
	input  logic            arst_n,
	bd_req_if.sink          req,
	input  logic            q_full,
	input  logic            clearing,
	output logic            push,
	output bd_pkg::bd_cmd_t cmd
);

	localparam int unsigned NREG = 8;
	localparam int unsigned OW = bd_pkg::OFS_W;
	localparam int unsigned SW = bd_pkg::SZ_W;

	localparam logic [32:0] BASE [NREG] = '{
		{1'b0, ROM_BASE_ADDR}, {1'b0, ROM_ALIAS_ADDR},
		{1'b0, bd_pkg::RAM_BASE0}, {1'b0, bd_pkg::RAM_BASE1}, {1'b0, bd_pkg::RAM_BASE2},
		{1'b0, bd_pkg::IO_BASE0}, {1'b0, bd_pkg::IO_BASE1}, {1'b0, bd_pkg::IO_BASE2}
	};
	localparam logic [SW-1:0] SIZE [NREG] = '{
		SW'(ROM_BYTES), SW'(ROM_BYTES),
		SW'(RAM_BYTES), SW'(RAM_BYTES), SW'(RAM_BYTES),
		SW'(IO_BYTES), SW'(IO_BYTES), SW'(IO_BYTES)
	};
	localparam bd_pkg::tgt_t REG_TGT [NREG] = '{
		bd_pkg::TGT_ROM, bd_pkg::TGT_ROM,
		bd_pkg::TGT_RAM, bd_pkg::TGT_RAM, bd_pkg::TGT_RAM,
		bd_pkg::TGT_IO, bd_pkg::TGT_IO, bd_pkg::TGT_IO
	};
	localparam logic [SW-1:0] TX_OFS = SW'(bd_pkg::UART_TX_OFS);
	localparam logic [OW-1:0] LSR_OFS = OW'(bd_pkg::UART_LSR_OFS);
	localparam logic [1:0] TX_LO = TX_OFS[1:0];

	logic            valid_s1;
	logic [2:0]      op_s1;
	logic [31:0]     wdata_s1;
	logic [NREG-1:0] hit_s1;
	logic [OW-1:0]   d_s1 [NREG];

	logic [32:0]     diff [NREG];
	logic [NREG-1:0] hit;

	logic            found;
	logic [OW-1:0]   sel_ofs;
	logic [SW-1:0]   sel_size;
	bd_pkg::tgt_t    sel_tgt;
	logic            legal;
	logic            wr;
	logic [1:0]      sz;
	logic [2:0]      nbytes;
	logic [SW-1:0]   end_ofs;
	logic            mapped;
	logic            is_io;
	logic [1:0]      tx_rel;
	logic [31:0]     tx_sh;

	assign req.ready = !clearing && (!valid_s1 || !q_full);
	assign push = valid_s1 && !q_full;

	for (genvar r = 0; r < NREG; r++) begin : g_rng
		assign diff[r] = {1'b0, req.address} - BASE[r];
		assign hit[r] = !diff[r][32] && (diff[r] < {{(33 - SW){1'b0}}, SIZE[r]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1 <= req.opcode;
			wdata_s1 <= req.write_data;
			hit_s1 <= hit;
			for (int r = 0; r < NREG; r++) begin
				d_s1[r] <= diff[r][OW-1:0];
			end
		end
	end

	always_comb begin
		found = 1'b0;
		sel_ofs = '0;
		sel_size = '0;
		sel_tgt = bd_pkg::TGT_NONE;
		for (int r = 0; r < NREG; r++) begin
			if (!found && hit_s1[r]) begin
				found = 1'b1;
				sel_ofs = d_s1[r];
				sel_size = SIZE[r];
				sel_tgt = REG_TGT[r];
			end
		end
	end

	always_comb begin
		legal = 1'b1;
		wr = 1'b0;
		sz = 2'd0;
		case (bd_pkg::op_t'(op_s1))
			bd_pkg::OP_RD8: begin
				sz = 2'd0;
			end
			bd_pkg::OP_RD16: begin
				sz = 2'd1;
			end
			bd_pkg::OP_RD32: begin
				sz = 2'd2;
			end
			bd_pkg::OP_WR8: begin
				wr = 1'b1;
				sz = 2'd0;
			end
			bd_pkg::OP_WR16: begin
				wr = 1'b1;
				sz = 2'd1;
			end
			bd_pkg::OP_WR32: begin
				wr = 1'b1;
				sz = 2'd2;
			end
			default: begin
				legal = 1'b0;
			end
		endcase
	end

	assign nbytes = 3'b001 << sz;
	assign end_ofs = SW'(sel_ofs) + SW'(nbytes);
	assign mapped = found && (end_ofs <= sel_size);
	assign is_io = legal && mapped && (sel_tgt == bd_pkg::TGT_IO);
	assign tx_rel = TX_LO - sel_ofs[1:0];
	assign tx_sh = wdata_s1 >> {tx_rel, 3'b000};

	always_comb begin
		cmd.tgt = (legal && mapped) ? sel_tgt : bd_pkg::TGT_NONE;
		cmd.wr = wr;
		cmd.sz = sz;
		cmd.ofs = sel_ofs;
		cmd.wdata = wdata_s1;
		cmd.unm = legal && !mapped;
		cmd.tx = is_io && wr && (SW'(sel_ofs) <= TX_OFS) && (TX_OFS < end_ofs);
		cmd.txb = cmd.tx ? tx_sh[7:0] : 8'd0;
		cmd.lsr_rd = is_io && !wr && (sz == 2'd0) && (sel_ofs == LSR_OFS);
	end

endmodule
`default_nettype wire

FILE: design/bd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_queue: command queue between decode and execution
// small register fifo of decoded commands
// ----------------------------------------------------------------------------
module bd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bd_pkg::bd_cmd_t push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            has_cmd,
	output bd_pkg::bd_cmd_t head
);

	localparam int unsigned DEPTH = bd_pkg::Q_DEPTH;
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bd_pkg::bd_cmd_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(DEPTH));
	assign has_cmd = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full command queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> has_cmd)
		else $error("pop from empty command queue");
`endif

endmodule
`default_nettype wire

FILE: design/bd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd_back: command execution on the byte stores
// four byte lanes per store, clearing sweep of the io store after reset,
// result register and the uart status update after a transmit write
// ----------------------------------------------------------------------------
module bd_back #(
	parameter int unsigned ROM_BYTES = bd_pkg::DEF_ROM_BYTES,
	parameter int unsigned RAM_BYTES = bd_pkg::DEF_RAM_BYTES,
	parameter int unsigned IO_BYTES = bd_pkg::DEF_IO_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            has_cmd,
	input  bd_pkg::bd_cmd_t head,
	output logic            pop,
	output logic            clearing,
	bd_rsp_if.source        rsp
);

	localparam int unsigned OW = bd_pkg::OFS_W;
	localparam int unsigned RWF = OW - 2;
	localparam int unsigned ROM_ROWS = (ROM_BYTES + 3) / 4;
	localparam int unsigned RAM_ROWS = (RAM_BYTES + 3) / 4;
	localparam int unsigned IO_ROWS = (IO_BYTES + 3) / 4;
	localparam int unsigned RW_ROM = $clog2(ROM_ROWS);
	localparam int unsigned RW_RAM = $clog2(RAM_ROWS);
	localparam int unsigned RW_IO = $clog2(IO_ROWS);
	localparam logic [1:0] LSR_LANE = 2'(bd_pkg::UART_LSR_OFS % 4);
	localparam logic [RW_IO-1:0] LSR_ROW = RW_IO'(bd_pkg::UART_LSR_OFS / 4);
	localparam logic [RW_IO-1:0] CLR_LAST = RW_IO'(IO_ROWS - 1);

	bd_pkg::bk_state_t state_q;
	bd_pkg::bk_state_t state_d;
	logic [RW_IO-1:0]  clr_q;
	bd_pkg::bd_cmd_t   cur_q;
	logic              out_valid_q;
	logic [31:0]       rdata_q;
	logic              unm_q;
	logic              txv_q;
	logic [7:0]        txb_q;

	logic              can_issue;
	logic              load_out;
	logic [2:0]        nhead;
	logic [2:0]        ncur;
	logic [1:0]        rel_l [4];
	logic [3:0]        lane_en;
	logic [RWF-1:0]    row_l [4];
	logic [31:0]       wsh_l [4];
	logic [7:0]        wb_l [4];

	logic [3:0]        rom_en;
	logic [3:0]        ram_en;
	logic [3:0]        io_en;
	logic              mem_we;
	logic              io_we;
	logic [RW_IO-1:0]  io_addr [4];
	logic [7:0]        io_wd [4];
	logic [7:0]        rom_rd [4];
	logic [7:0]        ram_rd [4];
	logic [7:0]        io_rd [4];
	logic [7:0]        sel_rd [4];
	logic [1:0]        lane_r [4];
	logic [31:0]       asm_rd;
	logic [31:0]       res_rd;

	assign clearing = (state_q == bd_pkg::BK_CLEAR);
	assign can_issue = has_cmd && (!out_valid_q || rsp.ready);
	assign nhead = 3'b001 << head.sz;
	assign ncur = 3'b001 << cur_q.sz;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			rel_l[j] = 2'(j) - head.ofs[1:0];
			lane_en[j] = ({1'b0, rel_l[j]} < nhead);
			row_l[j] = head.ofs[OW-1:2] + RWF'(2'(j) < head.ofs[1:0]);
			wsh_l[j] = head.wdata >> {rel_l[j], 3'b000};
			wb_l[j] = wsh_l[j][7:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bd_pkg::BK_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = bd_pkg::BK_IDLE;
				end
			end
			bd_pkg::BK_IDLE: begin
				if (can_issue) begin
					state_d = bd_pkg::BK_DATA;
				end
			end
			bd_pkg::BK_DATA: begin
				state_d = cur_q.tx ? bd_pkg::BK_STATUS : bd_pkg::BK_IDLE;
			end
			bd_pkg::BK_STATUS: begin
				state_d = bd_pkg::BK_IDLE;
			end
			default: begin
				state_d = bd_pkg::BK_IDLE;
			end
		endcase
	end

	// memory control
	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		rom_en = '0;
		ram_en = '0;
		io_en = '0;
		mem_we = head.wr;
		io_we = head.wr;
		for (int j = 0; j < 4; j++) begin
			io_addr[j] = row_l[j][RW_IO-1:0];
			io_wd[j] = wb_l[j];
		end
		case (state_q)
			bd_pkg::BK_CLEAR: begin
				io_en = 4'hF;
				io_we = 1'b1;
				for (int j = 0; j < 4; j++) begin
					io_addr[j] = clr_q;
					io_wd[j] = 8'd0;
				end
			end
			bd_pkg::BK_IDLE: begin
				if (can_issue) begin
					pop = 1'b1;
					rom_en = (head.tgt == bd_pkg::TGT_ROM) ? lane_en : 4'h0;
					ram_en = (head.tgt == bd_pkg::TGT_RAM) ? lane_en : 4'h0;
					io_en = (head.tgt == bd_pkg::TGT_IO) ? lane_en : 4'h0;
				end
			end
			bd_pkg::BK_DATA: begin
				load_out = 1'b1;
			end
			bd_pkg::BK_STATUS: begin
				io_we = 1'b1;
				io_en[LSR_LANE] = 1'b1;
				io_addr[LSR_LANE] = LSR_ROW;
				io_wd[LSR_LANE] = bd_pkg::UART_LSR_READY;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		bd_ram #(.WIDTH(8), .DEPTH(ROM_ROWS)) u_rom (
			.clk  (clk),
			.en   (rom_en[j]),
			.we   (mem_we),
			.addr (row_l[j][RW_ROM-1:0]),
			.wdata(wb_l[j]),
			.rdata(rom_rd[j])
		);
		bd_ram #(.WIDTH(8), .DEPTH(RAM_ROWS)) u_ram (
			.clk  (clk),
			.en   (ram_en[j]),
			.we   (mem_we),
			.addr (row_l[j][RW_RAM-1:0]),
			.wdata(wb_l[j]),
			.rdata(ram_rd[j])
		);
		bd_ram #(.WIDTH(8), .DEPTH(IO_ROWS)) u_io (
			.clk  (clk),
			.en   (io_en[j]),
			.we   (io_we),
			.addr (io_addr[j]),
			.wdata(io_wd[j]),
			.rdata(io_rd[j])
		);
	end

	// read data assembly
	always_comb begin
		asm_rd = '0;
		for (int j = 0; j < 4; j++) begin
			case (cur_q.tgt)
				bd_pkg::TGT_ROM: sel_rd[j] = rom_rd[j];
				bd_pkg::TGT_RAM: sel_rd[j] = ram_rd[j];
				bd_pkg::TGT_IO:  sel_rd[j] = io_rd[j];
				default:         sel_rd[j] = 8'd0;
			endcase
		end
		for (int r = 0; r < 4; r++) begin
			lane_r[r] = 2'(r) + cur_q.ofs[1:0];
			if (3'(r) < ncur) begin
				asm_rd[8*r +: 8] = sel_rd[lane_r[r]];
			end
		end
		if (cur_q.wr || cur_q.tgt == bd_pkg::TGT_NONE) begin
			res_rd = '0;
		end else if (cur_q.lsr_rd) begin
			res_rd = {24'd0, bd_pkg::UART_LSR_READY};
		end else begin
			res_rd = asm_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bd_pkg::BK_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bd_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load_out) begin
			rdata_q <= res_rd;
			unm_q <= cur_q.unm;
			txv_q <= cur_q.tx;
			txb_q <= cur_q.txb;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = rdata_q;
	assign rsp.unmapped = unm_q;
	assign rsp.tx_valid = txv_q;
	assign rsp.tx_byte = txb_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bd_pkg::BK_CLEAR) |-> !pop)
		else $error("command issued during io clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.unmapped) |-> (rsp.read_data == '0 && !rsp.tx_valid))
		else $error("unmapped transaction carries data or uart byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bd_pkg::BK_STATUS) |-> ($past(state_q) == bd_pkg::BK_DATA && cur_q.tx))
		else $error("status update without a uart transmit write");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || $past(rsp.ready)))
		else $error("result register overwritten before it was taken");
`endif

endmodule
`default_nettype wire

FILE: design/mirrored_bus_decoder_with_uart_stub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mirrored_bus_decoder_with_uart_stub: bus decoder with mirrored rom and uart
// decode front, command queue and execution back over byte-lane stores
// ----------------------------------------------------------------------------
// result path: request register, queue slot, lane rams, result register; the
//   back takes a new command only when idle, after the issue and read-data steps
//   on the single-port lane rams, plus the status update after a uart tx write
// reset: control state clears at once; the io store is then swept to zero row by
//   row, IO_BYTES/4 rows (32768 by default), with no request accepted meanwhile
module mirrored_bus_decoder_with_uart_stub #(
	parameter int unsigned ROM_BYTES = bd_pkg::DEF_ROM_BYTES,
	parameter int unsigned RAM_BYTES = bd_pkg::DEF_RAM_BYTES,
	parameter int unsigned IO_BYTES = bd_pkg::DEF_IO_BYTES,
	parameter logic [31:0] ROM_BASE_ADDR = bd_pkg::DEF_ROM_BASE_ADDR,
	parameter logic [31:0] ROM_ALIAS_ADDR = bd_pkg::DEF_ROM_ALIAS_ADDR
) (
	input  logic     clk,
	input  logic     arst_n,
	bd_req_if.sink   req,
	bd_rsp_if.source rsp
);

	logic            q_full;
	logic            has_cmd;
	logic            push;
	logic            pop;
	logic            clearing;
	bd_pkg::bd_cmd_t push_cmd;
	bd_pkg::bd_cmd_t head;

	bd_front #(
		.ROM_BYTES     (ROM_BYTES),
		.RAM_BYTES     (RAM_BYTES),
		.IO_BYTES      (IO_BYTES),
		.ROM_BASE_ADDR (ROM_BASE_ADDR),
		.ROM_ALIAS_ADDR(ROM_ALIAS_ADDR)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_full  (q_full),
		.clearing(clearing),
		.push    (push),
		.cmd     (push_cmd)
	);

	bd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.has_cmd (has_cmd),
		.head    (head)
	);

	bd_back #(
		.ROM_BYTES(ROM_BYTES),
		.RAM_BYTES(RAM_BYTES),
		.IO_BYTES (IO_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.has_cmd (has_cmd),
		.head    (head),
		.pop     (pop),
		.clearing(clearing),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

FILE: sim/mirrored_bus_decoder_with_uart_stub_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirrored_bus_decoder_with_uart_stub_tb: self-checking bench of the bus decoder
// a table of map edges, mirrors and uart cases, then random accesses checked
// against a byte-level model of the rom, ram and io stores; both channels idle
// at random and the response side holds off once long enough to stall requests
// ----------------------------------------------------------------------------
module mirrored_bus_decoder_with_uart_stub_tb;

	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;
	localparam int unsigned RAND_ITEMS = 1800;
	localparam int unsigned IDLE_PCT = 26;
	localparam int unsigned HOLD_AT = 400;
	localparam int unsigned HOLD_CYC = 300;
	localparam int unsigned CALM_FROM = 900;
	localparam int unsigned CALM_TO = 1200;
	localparam int unsigned HOT_DEPTH = 64;
	localparam int unsigned DRAIN_MAX = 20000;
	localparam int unsigned SETTLE_CYC = 16;
	localparam int unsigned LIMIT_NS = 1000000;
	localparam int unsigned MAX_SHOWN = 10;

	localparam logic [31:0] RAM_BASES [3] = '{bd_pkg::RAM_BASE0, bd_pkg::RAM_BASE1,
		bd_pkg::RAM_BASE2};
	localparam logic [31:0] IO_BASES [3] = '{bd_pkg::IO_BASE0, bd_pkg::IO_BASE1,
		bd_pkg::IO_BASE2};

	typedef struct packed {
		logic [31:0] read_data;
		logic        unmapped;
		logic        tx_valid;
		logic [7:0]  tx_byte;
	} bus_rsp_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic        typed;
		bus_rsp_t    want;
	} access_row_t;

	localparam int unsigned EDGE_N = 26;
	localparam access_row_t EDGE_ACCESSES [EDGE_N] = '{
		'{bd_pkg::OP_RD8,  32'hB801_8305, 32'h0, 1'b1, '{32'h0000_0020, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD16, 32'hB801_8304, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR8,  32'h1801_8300, 32'hFFFF_FFA5, 1'b1, '{32'h0, 1'b0, 1'b1, 8'hA5}},
		'{bd_pkg::OP_RD16, 32'hB801_8304, 32'h0, 1'b1, '{32'h0000_2000, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR32, 32'hB801_82FD, 32'h1122_3344, 1'b1, '{32'h0, 1'b0, 1'b1, 8'h11}},
		'{bd_pkg::OP_WR16, 32'h9801_82FF, 32'hCAFE_BEEF, 1'b1, '{32'h0, 1'b0, 1'b1, 8'hBE}},
		'{bd_pkg::OP_RD32, 32'h1801_82FD, 32'h0, 1'b0, '0},
		'{bd_pkg::OP_WR32, 32'hAFC0_0000, 32'hDEAD_BEEF, 1'b1, '{32'h0, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD32, 32'h0FC0_0000, 32'h0, 1'b1, '{32'hDEAD_BEEF, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD8,  32'hAFC0_0003, 32'h0, 1'b1, '{32'h0000_00DE, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR32, 32'hB03F_FFFC, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD16, 32'h103F_FFFE, 32'h0, 1'b1, '{32'h0000_FFFF, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD32, 32'hB03F_FFFE, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR16, 32'h007F_FFFF, 32'h0000_FFFF, 1'b1, '{32'h0, 1'b1, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR32, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD32, 32'h8000_0000, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR8,  32'hA07F_FFFF, 32'h1234_56FF, 1'b1, '{32'h0, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD8,  32'h007F_FFFF, 32'h0, 1'b1, '{32'h0000_00FF, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD32, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR32, 32'h4000_0000, 32'h5A5A_5A5A, 1'b1, '{32'h0, 1'b1, 1'b0, 8'h00}},
		'{OP_BAD6, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 8'h00}},
		'{OP_BAD7, 32'hB801_8300, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_WR32, 32'h1801_FFFC, 32'h8765_4321, 1'b1, '{32'h0, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD32, 32'hB801_FFFC, 32'h0, 1'b1, '{32'h8765_4321, 1'b0, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD16, 32'hB801_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 8'h00}},
		'{bd_pkg::OP_RD8,  32'h0FBF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 8'h00}}
	};

	logic clk = 1'b0;
	logic arst_n;

	bd_req_if req_ch ();
	bd_rsp_if rsp_ch ();

	mirrored_bus_decoder_with_uart_stub u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [7:0] rom_mem [int unsigned];
	logic [7:0] ram_mem [int unsigned];
	logic [7:0] io_mem [bd_pkg::DEF_IO_BYTES] = '{default: 8'h00};

	bus_rsp_t pending_rsp [$];
	logic [31:0] hot_addr [$];

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int unsigned n_sent = 0;
	int unsigned n_rd = 0;
	int unsigned n_wr = 0;
	int unsigned n_bad_op = 0;
	int unsigned n_checked = 0;
	int unsigned n_unm = 0;
	int unsigned n_tx = 0;
	int unsigned bad_rsp = 0;

	function automatic bit in_win(logic [31:0] a, logic [31:0] base, int unsigned span);
		return {32'h0, a} >= {32'h0, base} && {32'h0, a} < {32'h0, base} + 64'(span);
	endfunction

	function automatic int unsigned access_len(logic [2:0] op);
		case (op)
			bd_pkg::OP_RD8, bd_pkg::OP_WR8: return 1;
			bd_pkg::OP_RD16, bd_pkg::OP_WR16: return 2;
			bd_pkg::OP_RD32, bd_pkg::OP_WR32: return 4;
			default: return 0;
		endcase
	endfunction

	// region picked by start address in priority order, tail past the end drops it
	function automatic bd_pkg::tgt_t map_addr(input logic [31:0] a, input int unsigned n,
		output int unsigned ofs);
		bd_pkg::tgt_t tgt;
		logic [31:0] base;
		int unsigned span;
		tgt = bd_pkg::TGT_NONE;
		base = '0;
		if (in_win(a, bd_pkg::DEF_ROM_BASE_ADDR, bd_pkg::DEF_ROM_BYTES)) begin
			tgt = bd_pkg::TGT_ROM;
			base = bd_pkg::DEF_ROM_BASE_ADDR;
		end else if (in_win(a, bd_pkg::DEF_ROM_ALIAS_ADDR, bd_pkg::DEF_ROM_BYTES)) begin
			tgt = bd_pkg::TGT_ROM;
			base = bd_pkg::DEF_ROM_ALIAS_ADDR;
		end
		foreach (RAM_BASES[k]) begin
			if (tgt == bd_pkg::TGT_NONE && in_win(a, RAM_BASES[k], bd_pkg::DEF_RAM_BYTES)) begin
				tgt = bd_pkg::TGT_RAM;
				base = RAM_BASES[k];
			end
		end
		foreach (IO_BASES[k]) begin
			if (tgt == bd_pkg::TGT_NONE && in_win(a, IO_BASES[k], bd_pkg::DEF_IO_BYTES)) begin
				tgt = bd_pkg::TGT_IO;
				base = IO_BASES[k];
			end
		end
		case (tgt)
			bd_pkg::TGT_ROM: span = bd_pkg::DEF_ROM_BYTES;
			bd_pkg::TGT_RAM: span = bd_pkg::DEF_RAM_BYTES;
			default: span = bd_pkg::DEF_IO_BYTES;
		endcase
		ofs = a - base;
		if (tgt != bd_pkg::TGT_NONE && ofs + n > span)
			tgt = bd_pkg::TGT_NONE;
		return tgt;
	endfunction

	function automatic bit has_unwritten(logic [2:0] op, logic [31:0] addr);
		int unsigned n;
		int unsigned ofs;
		int unsigned i;
		bd_pkg::tgt_t tgt;
		n = access_len(op);
		if (n == 0 || op >= bd_pkg::OP_WR8)
			return 1'b0;
		tgt = map_addr(addr, n, ofs);
		for (i = 0; i < n; i++) begin
			if (tgt == bd_pkg::TGT_ROM && !rom_mem.exists(ofs + i))
				return 1'b1;
			if (tgt == bd_pkg::TGT_RAM && !ram_mem.exists(ofs + i))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bus_rsp_t bus_access(logic [2:0] op, logic [31:0] addr,
		logic [31:0] wdata);
		bus_rsp_t r;
		bd_pkg::tgt_t tgt;
		int unsigned n;
		int unsigned ofs;
		int unsigned i;
		logic [7:0] lane;
		r = '0;
		n = access_len(op);
		if (n == 0)
			return r;
		tgt = map_addr(addr, n, ofs);
		if (tgt == bd_pkg::TGT_NONE) begin
			r.unmapped = 1'b1;
			return r;
		end
		for (i = 0; i < n; i++) begin
			lane = wdata[8*i +: 8];
			if (op < bd_pkg::OP_WR8) begin
				case (tgt)
					bd_pkg::TGT_ROM: lane = rom_mem[ofs + i];
					bd_pkg::TGT_RAM: lane = ram_mem[ofs + i];
					default: lane = io_mem[ofs + i];
				endcase
				r.read_data[8*i +: 8] = lane;
			end else begin
				case (tgt)
					bd_pkg::TGT_ROM: rom_mem[ofs + i] = lane;
					bd_pkg::TGT_RAM: ram_mem[ofs + i] = lane;
					default: io_mem[ofs + i] = lane;
				endcase
				if (tgt == bd_pkg::TGT_IO && ofs + i == bd_pkg::UART_TX_OFS) begin
					r.tx_valid = 1'b1;
					r.tx_byte = lane;
				end
			end
		end
		if (r.tx_valid)
			io_mem[bd_pkg::UART_LSR_OFS] = bd_pkg::UART_LSR_READY;
		if (tgt == bd_pkg::TGT_IO && op == bd_pkg::OP_RD8 && ofs == bd_pkg::UART_LSR_OFS)
			r.read_data = {24'h0, bd_pkg::UART_LSR_READY};
		return r;
	endfunction

	// offsets cluster at both ends of a region so reads find written bytes
	function automatic int unsigned pick_ofs(int unsigned span);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return $urandom_range(63);
		if (pick < 70)
			return span - 1 - $urandom_range(63);
		return $urandom_range(span - 1);
	endfunction

	function automatic access_row_t random_access();
		access_row_t row;
		int unsigned pick;
		int unsigned ofs;
		row = '0;
		row.wdata = $urandom;
		row.op = 3'($urandom_range(bd_pkg::OP_WR32));
		pick = $urandom_range(99);
		if (pick < 20) begin
			row.addr = ($urandom_range(1) ? bd_pkg::DEF_ROM_BASE_ADDR
				: bd_pkg::DEF_ROM_ALIAS_ADDR) + pick_ofs(bd_pkg::DEF_ROM_BYTES);
		end else if (pick < 50) begin
			row.addr = RAM_BASES[$urandom_range(2)] + pick_ofs(bd_pkg::DEF_RAM_BYTES);
		end else if (pick < 82) begin
			if ($urandom_range(99) < 40)
				ofs = bd_pkg::UART_TX_OFS - 4 + $urandom_range(12);
			else
				ofs = pick_ofs(bd_pkg::DEF_IO_BYTES);
			row.addr = IO_BASES[$urandom_range(2)] + ofs;
		end else if (pick < 92 && hot_addr.size() != 0) begin
			row.addr = hot_addr[$urandom_range(hot_addr.size() - 1)];
		end else begin
			row.addr = $urandom;
		end
		if ($urandom_range(99) < 2)
			row.op = $urandom_range(1) ? OP_BAD6 : OP_BAD7;
		// never read rom or ram bytes that hold nothing yet
		if (has_unwritten(row.op, row.addr))
			row.op = 3'(row.op + bd_pkg::OP_WR8);
		if (row.op >= bd_pkg::OP_WR8 && row.op <= bd_pkg::OP_WR32) begin
			hot_addr.push_back(row.addr);
			if (hot_addr.size() > HOT_DEPTH)
				void'(hot_addr.pop_front());
		end
		return row;
	endfunction

	task automatic send_access(input access_row_t row);
		bus_rsp_t pred;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= row.op;
		req_ch.address <= row.addr;
		req_ch.write_data <= row.wdata;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pred = bus_access(row.op, row.addr, row.wdata);
		pending_rsp.push_back(row.typed ? row.want : pred);
		n_sent++;
		if (access_len(row.op) == 0)
			n_bad_op++;
		else if (row.op >= bd_pkg::OP_WR8)
			n_wr++;
		else
			n_rd++;
		@(negedge clk);
	endtask

	initial begin : req_drive
		access_row_t row;
		int unsigned k;
		int unsigned waited;
		req_ch.valid = 1'b0;
		req_ch.opcode = bd_pkg::OP_RD8;
		req_ch.address = '0;
		req_ch.write_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (EDGE_ACCESSES[i])
			send_access(EDGE_ACCESSES[i]);
		for (k = 0; k < RAND_ITEMS; k++) begin
			calm = k >= CALM_FROM && k < CALM_TO;
			if (k == HOLD_AT)
				hold_req = 1'b1;
			row = random_access();
			send_access(row);
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (pending_rsp.size() != 0)
			$display("%0d expected results never arrived", pending_rsp.size());
		$display("sent %0d transactions: %0d reads, %0d writes, %0d undefined opcodes",
			n_sent, n_rd, n_wr, n_bad_op);
		$display("compared %0d results: %0d unmapped, %0d uart bytes, %0d bad",
			n_checked, n_unm, n_tx, bad_rsp);
		if (bad_rsp == 0 && pending_rsp.size() == 0) begin
			$display("mirrored_bus_decoder_with_uart_stub_tb: PASS");
		end else begin
			$display("mirrored_bus_decoder_with_uart_stub_tb: FAIL");
		end
		$finish;
	end

	// one long hold-off lets the queue fill and back up the request side
	initial begin : rsp_drive
		bit held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : rsp_check
		bus_rsp_t got;
		bus_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.read_data, rsp_ch.unmapped, rsp_ch.tx_valid, rsp_ch.tx_byte};
			if (pending_rsp.size() == 0) begin
				bad_rsp++;
				if (bad_rsp <= MAX_SHOWN)
					$display("%0t: unexpected transaction: read_data %h unmapped %b tx %b %h",
						$time, got.read_data, got.unmapped, got.tx_valid, got.tx_byte);
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				if (want.unmapped)
					n_unm++;
				if (want.tx_valid)
					n_tx++;
				if (got !== want) begin
					bad_rsp++;
					if (bad_rsp <= MAX_SHOWN)
						$display({"%0t: result %0d: read_data %h/%h unmapped %b/%b",
							" tx_valid %b/%b tx_byte %h/%h (expected/actual)"},
							$time, n_checked, want.read_data, got.read_data,
							want.unmapped, got.unmapped, want.tx_valid, got.tx_valid,
							want.tx_byte, got.tx_byte);
				end
			end
		end
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("timeout after %0d ns", LIMIT_NS);
		$display("mirrored_bus_decoder_with_uart_stub_tb: FAIL");
		$finish;
	end

endmodule
